[rtl/core/ssvg_pkg.sv]
// Shared types and constants for the sphere strip vertex generator.
package ssvg_pkg;

  // Width of the points-per-turn register and of the grid indices derived from it
  localparam int CFG_W = 11;
  localparam int LAT_W = 9;
  localparam int LON_W = 11;

  // Reset value of the points-per-turn register
  localparam int CFG_RST = 64;

  // Fraction bits of the texture coordinates
  localparam int TEX_FRAC = 16;

  // Angle magnitude in radians, unsigned Q1.30
  localparam int X_W = 31;

  // Register-enabled stages of the sine evaluator
  localparam int SIN_LAT = 13;

  // Cell queue between the front and the back
  localparam int FIFO_DEPTH = 4;

  // Register index of points_per_turn
  localparam logic REG_POINTS = 1'b0;

  // One clamped grid cell
  typedef struct packed {
    logic [LAT_W-1:0] lat;
    logic [LON_W-1:0] lon;
  } cell_t;

endpackage

[rtl/core/sphere_strip_vertex_gen.sv]
// Top level of the UV-sphere triangle-strip vertex generator.
// Each cell yields two vertices on the single result channel, the second following the first;
// the back end takes a new cell only once it has issued both vertices of the previous one.
// Reset: points_per_turn = 64 with its reciprocal preset; no startup stall.
// A points_per_turn write stalls input while the serial reciprocal unit recomputes 2^NUMW / N.
module sphere_strip_vertex_gen #(
  parameter int MAX_POINTS = 1024,
  parameter int ANGLE_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [8:0]         lat_index_i,
  input  logic [10:0]        lon_index_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] pos_x_o,
  output logic signed [15:0] pos_y_o,
  output logic signed [15:0] pos_z_o,
  output logic signed [15:0] norm_x_o,
  output logic signed [15:0] norm_y_o,
  output logic signed [15:0] norm_z_o,
  output logic [17:0]        tex_u_o,
  output logic [16:0]        tex_v_o,
  output logic               last_o
);

  localparam int NW    = ssvg_pkg::CFG_W;
  localparam int SW    = (ANGLE_BITS > ssvg_pkg::TEX_FRAC) ? ANGLE_BITS : ssvg_pkg::TEX_FRAC;
  localparam int NUMW  = NW + SW + 1;
  localparam int RW    = NUMW - 1;
  localparam int MAXN  = (MAX_POINTS > 2047) ? 2047 : MAX_POINTS;
  localparam int N_RST = ((ssvg_pkg::CFG_RST > MAXN) ? MAXN : ssvg_pkg::CFG_RST) / 2 * 2;
  localparam logic [RW-1:0] RECIP_RST = RW'((64'd1 << NUMW) / 64'(N_RST));

  logic [NW-1:0]   cfg_q, n_q, wd, nc;
  logic            cfg_wr, busy;
  logic [RW-1:0]   recip;
  ssvg_pkg::cell_t head;
  logic            head_valid, pop;
  logic [15:0]     px, py, pz;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == ssvg_pkg::REG_POINTS);
  assign prdata = (paddr[2] == ssvg_pkg::REG_POINTS) ? {21'd0, cfg_q} : 32'd0;

  // effective N: clamped to the supported range and made even
  always_comb begin
    wd = pwdata[NW-1:0];
    if (wd < NW'(4)) begin
      nc = NW'(4);
    end else if (wd > NW'(MAXN)) begin
      nc = NW'(MAXN);
    end else begin
      nc = wd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= NW'(ssvg_pkg::CFG_RST);
      n_q   <= NW'(N_RST);
    end else if (cfg_wr) begin
      cfg_q <= wd;
      n_q   <= {nc[NW-1:1], 1'b0};
    end
  end

  ssvg_recip #(
    .NUMW    (NUMW),
    .RW      (RW),
    .RST_VAL (RECIP_RST)
  ) u_recip (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cfg_wr),
    .n_i     (n_q),
    .busy_o  (busy),
    .recip_o (recip)
  );

  ssvg_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .n_i          (n_q),
    .hold_i       (busy),
    .in_valid_i   (in_valid_i),
    .lat_index_i  (lat_index_i),
    .lon_index_i  (lon_index_i),
    .in_stall_o   (in_stall_o),
    .head_o       (head),
    .head_valid_o (head_valid),
    .pop_i        (pop)
  );

  ssvg_back #(
    .ANGLE_BITS (ANGLE_BITS),
    .NUMW       (NUMW),
    .RW         (RW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .n_i          (n_q),
    .recip_i      (recip),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .pos_x_o      (px),
    .pos_y_o      (py),
    .pos_z_o      (pz),
    .tex_u_o      (tex_u_o),
    .tex_v_o      (tex_v_o),
    .last_o       (last_o)
  );

  // the normal of a unit sphere is its position
  assign pos_x_o  = $signed(px);
  assign pos_y_o  = $signed(py);
  assign pos_z_o  = $signed(pz);
  assign norm_x_o = $signed(px);
  assign norm_y_o = $signed(py);
  assign norm_z_o = $signed(pz);

`ifndef SYNTHESIS
  // a points_per_turn write always starts a reciprocal pass that holds off requests
  a_cfg_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> in_stall_o)
    else $error("input not held after points_per_turn write");

  // the second vertex of a pair follows the first directly
  a_pair_adjacent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o && last_o)
    else $error("second vertex did not follow the first");

  // v never exceeds 1.0
  a_tex_v_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> tex_v_o <= 17'd65536)
    else $error("tex_v out of range");

  // clamped rounding never yields the most negative code
  a_pos_z_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pos_z_o != 16'sh8000)
    else $error("pos_z not clamped");
`endif

endmodule

[rtl/core/ssvg_sin.sv]
// Pipelined first-quadrant sine, truncating Horner series to x^9 in Q30.
module ssvg_sin (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [ssvg_pkg::X_W-1:0]  x_i,
  output logic [31:0]               sin_o
);

  localparam logic [30:0] ONE = 31'h4000_0000;
  // floor(2^32 / d) for the odd parts of the series divisors
  localparam logic [30:0] M9  = 31'd477218588;
  localparam logic [30:0] M21 = 31'd204522252;
  localparam logic [30:0] M5  = 31'd858993459;
  localparam logic [30:0] M3  = 31'd1431655765;

  // Quotient estimate is low by at most one; fix it and form the next Horner term
  function automatic logic [30:0] tstep(input logic [31:0] qe, input logic [31:0] v,
                                        input logic [31:0] d);
    logic [31:0] r;
    logic [31:0] q;
    r = v - 32'(qe * d);
    q = (r >= d) ? qe + 32'd1 : qe;
    return ONE - q[30:0];
  endfunction

  logic [30:0] x_q [1:12];
  logic [31:0] x2_q [2:9];
  logic [61:0] xx1_q;
  logic [31:0] va2_q, vb5_q, vc8_q, vd11_q;
  logic [62:0] pa2_q, pc5_q, pe8_q, pg11_q;
  logic [62:0] pb4_q, pd7_q, pf10_q;
  logic [30:0] t3_q, t6_q, t9_q, t12_q;
  logic [61:0] ph13_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // operand carry lines
      x_q[1] <= x_i;
      for (int k = 2; k <= 12; k++) begin
        x_q[k] <= x_q[k-1];
      end
      x2_q[2] <= xx1_q[61:30];
      for (int k = 3; k <= 9; k++) begin
        x2_q[k] <= x2_q[k-1];
      end
      // x^2
      xx1_q <= {31'd0, x_i} * {31'd0, x_i};
      // t = 1 - x2/72
      va2_q <= {3'd0, xx1_q[61:33]};
      pa2_q <= 63'({3'd0, xx1_q[61:33]}) * 63'(M9);
      t3_q  <= tstep({1'b0, pa2_q[62:32]}, va2_q, 32'd9);
      // t = 1 - x2*t/42
      pb4_q <= 63'(x2_q[3]) * 63'(t3_q);
      vb5_q <= {1'b0, pb4_q[61:31]};
      pc5_q <= 63'({1'b0, pb4_q[61:31]}) * 63'(M21);
      t6_q  <= tstep({1'b0, pc5_q[62:32]}, vb5_q, 32'd21);
      // t = 1 - x2*t/20
      pd7_q <= 63'(x2_q[6]) * 63'(t6_q);
      vc8_q <= {2'd0, pd7_q[61:32]};
      pe8_q <= 63'({2'd0, pd7_q[61:32]}) * 63'(M5);
      t9_q  <= tstep({1'b0, pe8_q[62:32]}, vc8_q, 32'd5);
      // t = 1 - x2*t/6
      pf10_q <= 63'(x2_q[9]) * 63'(t9_q);
      vd11_q <= {1'b0, pf10_q[61:31]};
      pg11_q <= 63'({1'b0, pf10_q[61:31]}) * 63'(M3);
      t12_q  <= tstep({1'b0, pg11_q[62:32]}, vd11_q, 32'd3);
      // sin = x*t
      ph13_q <= {31'd0, x_q[12]} * {31'd0, t12_q};
    end
  end

  assign sin_o = ph13_q[61:30];

endmodule

[rtl/core/ssvg_recip.sv]
// Serial reciprocal unit: floor(2^NUMW / N), one quotient bit per cycle.
module ssvg_recip #(
  parameter int          NUMW    = 28,
  parameter int          RW      = 27,
  parameter logic [RW-1:0] RST_VAL = '0
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ssvg_pkg::CFG_W-1:0] n_i,
  output logic                       busy_o,
  output logic [RW-1:0]              recip_o
);

  localparam int CW = $clog2(NUMW + 1);

  logic                       busy_q;
  logic [CW-1:0]              cnt_q;
  logic [ssvg_pkg::CFG_W-1:0] rem_q, rem_d;
  logic [RW-1:0]              recip_q;
  logic [ssvg_pkg::CFG_W:0]   sh;
  logic                       ge;

  // restoring step; the dividend is a single one at bit NUMW
  always_comb begin
    sh    = {rem_q, (cnt_q == '0)};
    ge    = (sh >= {1'b0, n_i});
    rem_d = ge ? ssvg_pkg::CFG_W'(sh - {1'b0, n_i}) : sh[ssvg_pkg::CFG_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      cnt_q   <= '0;
      rem_q   <= '0;
      recip_q <= RST_VAL;
    end else if (start_i) begin
      busy_q  <= 1'b1;
      cnt_q   <= '0;
      rem_q   <= '0;
      recip_q <= '0;
    end else if (busy_q) begin
      rem_q   <= rem_d;
      recip_q <= {recip_q[RW-2:0], ge};
      cnt_q   <= cnt_q + 1'b1;
      if (cnt_q == CW'(NUMW)) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign busy_o  = busy_q;
  assign recip_o = recip_q;

endmodule

[rtl/core/ssvg_front.sv]
// Front end: takes requests, clamps the indices and queues cells for the back end.
module ssvg_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [ssvg_pkg::CFG_W-1:0] n_i,
  input  logic                       hold_i,
  input  logic                       in_valid_i,
  input  logic [ssvg_pkg::LAT_W-1:0] lat_index_i,
  input  logic [ssvg_pkg::LON_W-1:0] lon_index_i,
  output logic                       in_stall_o,
  output ssvg_pkg::cell_t            head_o,
  output logic                       head_valid_o,
  input  logic                       pop_i
);

  localparam int PTR_W = $clog2(ssvg_pkg::FIFO_DEPTH);

  ssvg_pkg::cell_t            mem_q [ssvg_pkg::FIFO_DEPTH];
  ssvg_pkg::cell_t            clamped;
  logic [PTR_W-1:0]           wptr_q, rptr_q;
  logic [PTR_W:0]             cnt_q;
  logic [ssvg_pkg::CFG_W-2:0] lat_max;
  logic                       push, pop, full;

  // saturate the indices to the last valid grid point
  always_comb begin
    lat_max = n_i[ssvg_pkg::CFG_W-1:1] - 1'b1;
    clamped.lat = ({1'b0, lat_index_i} > lat_max) ? lat_max[ssvg_pkg::LAT_W-1:0] : lat_index_i;
    clamped.lon = (lon_index_i > n_i) ? n_i : lon_index_i;
  end

  assign full       = (cnt_q == (PTR_W+1)'(ssvg_pkg::FIFO_DEPTH));
  assign in_stall_o = full || hold_i;
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = pop_i && (cnt_q != '0);

  // cell queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= clamped;
    end
  end

  assign head_o       = mem_q[rptr_q];
  assign head_valid_o = (cnt_q != '0);

endmodule

[rtl/core/ssvg_back.sv]
// Back end: issues two vertices per cell, divides by N, evaluates sin/cos, forms outputs.
module ssvg_back #(
  parameter int ANGLE_BITS = 16,
  parameter int NUMW       = 28,
  parameter int RW         = 27
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [ssvg_pkg::CFG_W-1:0] n_i,
  input  logic [RW-1:0]              recip_i,
  input  ssvg_pkg::cell_t            head_i,
  input  logic                       head_valid_i,
  output logic                       pop_o,
  input  logic                       out_stall_i,
  output logic                       out_valid_o,
  output logic [15:0]                pos_x_o,
  output logic [15:0]                pos_y_o,
  output logic [15:0]                pos_z_o,
  output logic [17:0]                tex_u_o,
  output logic [16:0]                tex_v_o,
  output logic                       last_o
);

  localparam int AB   = ANGLE_BITS;
  localparam int NW   = ssvg_pkg::CFG_W;
  localparam int PIPE = 5 + ssvg_pkg::SIN_LAT + 2;
  localparam int PW   = NUMW + RW;
  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  typedef struct packed {
    logic [1:0]  quad_lat;
    logic [1:0]  quad_lon;
    logic [17:0] u;
    logic [16:0] v;
    logic        last;
  } side_t;

  // signed sine and cosine from the quadrant and first-quadrant values
  function automatic logic [63:0] quad_fix(input logic [1:0] q, input logic [31:0] s,
                                           input logic [31:0] c);
    logic signed [31:0] ps, pc;
    logic [63:0] res;
    ps = $signed(s);
    pc = $signed(c);
    unique case (q)
      2'd0: res = {ps, pc};
      2'd1: res = {pc, -ps};
      2'd2: res = {-ps, -pc};
      2'd3: res = {-pc, ps};
    endcase
    return res;
  endfunction

  // round half away from zero to Q1.15 and clamp the magnitude
  function automatic logic [15:0] to_q15(input logic signed [63:0] v, input int sh);
    logic [63:0] mag;
    logic [15:0] m16;
    mag = v[63] ? 64'(-v) : 64'(v);
    mag = (mag + (64'd1 << (sh - 1))) >> sh;
    m16 = (mag > 64'd32767) ? 16'd32767 : mag[15:0];
    return v[63] ? 16'(-m16) : m16;
  endfunction

  logic adv, issue;
  logic phase_q;
  logic [PIPE-1:0] vld_q;
  logic out_valid_q;

  logic [NW-2:0]   lat_k;
  logic [NW-1:0]   lon_k;
  logic [NW-2:0]   nh;
  logic [NUMW-1:0] num0 [4];

  logic [NUMW-1:0] num1_q [4];
  logic [NUMW-1:0] num2_q [4];
  logic [PW-1:0]   prod2_q [4];
  logic [NUMW-1:0] num3_q [4];
  logic [RW-1:0]   qe3_q [4];
  logic [NUMW-1:0] qn3_q [4];
  logic [RW-1:0]   q4_q [4];
  logic [3:0]      last_q;

  logic [AB-3:0]   rem [2];
  logic [AB+29:0]  xprod [2];
  logic [30:0]     xs5_q [2];
  side_t           side5;
  side_t           sd_q [0:ssvg_pkg::SIN_LAT];
  logic [31:0]     sv [4];

  logic [63:0]        lat_sc, lon_sc;
  logic signed [31:0] st_q, ct_q, sp_q, cp_q;
  side_t              e1_q, e2_q;
  logic signed [63:0] px_q, py_q, pz_q;
  logic [15:0]        px_o_q, py_o_q, pz_o_q;
  logic [17:0]        u_o_q;
  logic [16:0]        v_o_q;
  logic               last_o_q;

  // the whole pipeline moves when the output register can take a vertex
  assign adv   = !out_valid_q || !out_stall_i;
  assign issue = adv && head_valid_i;
  assign pop_o = issue && phase_q;

  // numerators of the four divisions by N
  always_comb begin
    lat_k = {1'b0, head_i.lat} + (NW-1)'(phase_q);
    lon_k = head_i.lon + NW'(phase_q);
    nh    = n_i[NW-1:1];
    num0[0] = (NUMW'(lat_k) << AB) + NUMW'(nh);
    num0[1] = (NUMW'(lon_k) << AB) + NUMW'(nh);
    num0[2] = (NUMW'(lon_k) << ssvg_pkg::TEX_FRAC) + NUMW'(nh);
    num0[3] = (NUMW'(n_i - {lat_k, 1'b0}) << ssvg_pkg::TEX_FRAC) + NUMW'(nh);
  end

  // quadrant split and remainder to radians
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      rem[i]   = q4_q[i][AB-3:0];
      xprod[i] = (AB+30)'(rem[i]) * (AB+30)'(PI_Q30);
    end
    side5.quad_lat = q4_q[0][AB-1:AB-2];
    side5.quad_lon = q4_q[1][AB-1:AB-2];
    side5.u        = q4_q[2][17:0];
    side5.v        = q4_q[3][16:0];
    side5.last     = last_q[3];
  end

  // control: issue phase and valid line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 1'b0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      if (head_valid_i) begin
        phase_q <= ~phase_q;
      end
      vld_q       <= {vld_q[PIPE-2:0], issue};
      out_valid_q <= vld_q[PIPE-1];
    end
  end

  // divide stages: multiply by reciprocal, then one correction step
  always_ff @(posedge clk_i) begin
    if (adv) begin
      last_q <= {last_q[2:0], phase_q};
      for (int i = 0; i < 4; i++) begin
        num1_q[i]  <= num0[i];
        num2_q[i]  <= num1_q[i];
        prod2_q[i] <= PW'(num1_q[i]) * PW'(recip_i);
        num3_q[i]  <= num2_q[i];
        qe3_q[i]   <= prod2_q[i][PW-1:NUMW];
        qn3_q[i]   <= NUMW'(prod2_q[i][PW-1:NUMW] * n_i);
        q4_q[i]    <= qe3_q[i] +
                      RW'((num3_q[i] - qn3_q[i]) >= NUMW'(n_i));
      end
      for (int i = 0; i < 2; i++) begin
        xs5_q[i] <= xprod[i][AB+29:AB-1];
      end
      sd_q[0] <= side5;
      for (int k = 1; k <= ssvg_pkg::SIN_LAT; k++) begin
        sd_q[k] <= sd_q[k-1];
      end
    end
  end

  // sine and cosine lanes for the latitude and longitude angles
  ssvg_sin u_sin_lat (
    .clk_i (clk_i), .en_i (adv), .x_i (xs5_q[0]), .sin_o (sv[0])
  );
  ssvg_sin u_cos_lat (
    .clk_i (clk_i), .en_i (adv), .x_i (HALF_PI_Q30 - xs5_q[0]), .sin_o (sv[1])
  );
  ssvg_sin u_sin_lon (
    .clk_i (clk_i), .en_i (adv), .x_i (xs5_q[1]), .sin_o (sv[2])
  );
  ssvg_sin u_cos_lon (
    .clk_i (clk_i), .en_i (adv), .x_i (HALF_PI_Q30 - xs5_q[1]), .sin_o (sv[3])
  );

  always_comb begin
    lat_sc = quad_fix(sd_q[ssvg_pkg::SIN_LAT].quad_lat, sv[0], sv[1]);
    lon_sc = quad_fix(sd_q[ssvg_pkg::SIN_LAT].quad_lon, sv[2], sv[3]);
  end

  // sign, products, rounding
  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_q <= $signed(lat_sc[63:32]);
      ct_q <= $signed(lat_sc[31:0]);
      sp_q <= $signed(lon_sc[63:32]);
      cp_q <= $signed(lon_sc[31:0]);
      e1_q <= sd_q[ssvg_pkg::SIN_LAT];
      px_q <= 64'(st_q) * 64'(cp_q);
      py_q <= 64'(st_q) * 64'(sp_q);
      pz_q <= 64'(ct_q);
      e2_q <= e1_q;
      px_o_q   <= to_q15(px_q, 45);
      py_o_q   <= to_q15(py_q, 45);
      pz_o_q   <= to_q15(pz_q, 15);
      u_o_q    <= e2_q.u;
      v_o_q    <= e2_q.v;
      last_o_q <= e2_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = px_o_q;
  assign pos_y_o     = py_o_q;
  assign pos_z_o     = pz_o_q;
  assign tex_u_o     = u_o_q;
  assign tex_v_o     = v_o_q;
  assign last_o      = last_o_q;

endmodule

[bench/ssvg_checker.sv]
// Vertex predictor and result checker for the sphere strip vertex generator.
`timescale 1ns / 1ps
module ssvg_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [10:0]        cfg_points_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [8:0]         lat_index_i,
  input  logic [10:0]        lon_index_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic signed [15:0] pos_z_i,
  input  logic signed [15:0] norm_x_i,
  input  logic signed [15:0] norm_y_i,
  input  logic signed [15:0] norm_z_i,
  input  logic [17:0]        tex_u_i,
  input  logic [16:0]        tex_v_i,
  input  logic               last_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 vertex_count_o
);

  localparam longint unsigned Q30 = 64'd1073741824;
  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam int ABITS = 16;

  typedef struct packed {
    logic [15:0] px, py, pz;
    logic [17:0] u;
    logic [16:0] v;
    logic        last;
  } vertex_t;

  vertex_t vertex_q[$];

  // Truncating Horner series for sine, x in Q2.30
  function automatic longint unsigned sin_q30(longint unsigned x);
    longint unsigned x2, t;
    x2 = (x * x) >> 30;
    t = Q30 - x2 / 72;
    t = Q30 - ((x2 * t) >> 30) / 42;
    t = Q30 - ((x2 * t) >> 30) / 20;
    t = Q30 - ((x2 * t) >> 30) / 6;
    return (x * t) >> 30;
  endfunction

  function automatic longint unsigned grid_angle(longint unsigned k, longint unsigned n);
    return (((k << ABITS) + n / 2) / n) & ((64'd1 << ABITS) - 1);
  endfunction

  // Signed sine and cosine in Q30 from a turn-fraction angle
  function automatic void sincos(longint unsigned a, output longint s, output longint c);
    longint unsigned r, x;
    longint sv, cv;
    r = a & ((64'd1 << (ABITS - 2)) - 1);
    x = (r * PI_Q30) >> (ABITS - 1);
    sv = longint'(sin_q30(x));
    cv = longint'(sin_q30(HALF_PI_Q30 - x));
    case ((a >> (ABITS - 2)) & 3)
      0: begin s = sv; c = cv; end
      1: begin s = cv; c = -sv; end
      2: begin s = -sv; c = -cv; end
      default: begin s = -cv; c = sv; end
    endcase
  endfunction

  // Round half away from zero, clamp magnitude to 32767
  function automatic logic [15:0] round_q15(longint v, int sh);
    longint unsigned m;
    bit neg;
    neg = v < 0;
    m = neg ? longint'(-v) : v;
    m = (m + (64'd1 << (sh - 1))) >> sh;
    if (m > 32767) m = 32767;
    return neg ? -16'(m) : 16'(m);
  endfunction

  function automatic vertex_t make_vertex(longint unsigned lat, longint unsigned lon,
                                          longint unsigned n, bit last);
    vertex_t vx;
    longint st, ct, sp, cp;
    sincos(grid_angle(lat, n), st, ct);
    sincos(grid_angle(lon, n), sp, cp);
    vx.px = round_q15(st * cp, 45);
    vx.py = round_q15(st * sp, 45);
    vx.pz = round_q15(ct, 15);
    vx.u = 18'((lon * 65536 + n / 2) / n);
    vx.v = 17'(((n - 2 * lat) * 65536 + n / 2) / n);
    vx.last = last;
    return vx;
  endfunction

  // Queue both strip vertices for an accepted cell request, then compare
  // each accepted vertex against the oldest prediction
  always @(posedge clk_i) begin
    longint unsigned n, lat, lon;
    vertex_t e;
    if (rst_ni && in_valid_i && !in_stall_i) begin
      n = cfg_points_i;
      if (n < 4) n = 4;
      if (n > 1024) n = 1024;
      n = n & ~64'd1;
      lat = lat_index_i;
      lon = lon_index_i;
      if (lat > n / 2 - 1) lat = n / 2 - 1;
      if (lon > n) lon = n;
      vertex_q = {vertex_q, make_vertex(lat, lon, n, 1'b0)};
      vertex_q = {vertex_q, make_vertex(lat + 1, lon + 1, n, 1'b1)};
    end
    if (rst_ni && out_valid_i && !out_stall_i) begin
      vertex_count_o <= vertex_count_o + 1;
      if (vertex_q.size() == 0) begin
        $error("unexpected vertex");
        fail_count_o <= fail_count_o + 1;
      end else begin
        e = vertex_q.pop_front();
        if (pos_x_i !== e.px || norm_x_i !== e.px || pos_y_i !== e.py ||
            norm_y_i !== e.py || pos_z_i !== e.pz || norm_z_i !== e.pz ||
            tex_u_i !== e.u || tex_v_i !== e.v || last_i !== e.last)
          fail_count_o <= fail_count_o + 1;
        if (pos_x_i !== e.px) $error("pos_x exp %0d got %0d", $signed(e.px), pos_x_i);
        if (pos_y_i !== e.py) $error("pos_y exp %0d got %0d", $signed(e.py), pos_y_i);
        if (pos_z_i !== e.pz) $error("pos_z exp %0d got %0d", $signed(e.pz), pos_z_i);
        if (norm_x_i !== e.px) $error("norm_x exp %0d got %0d", $signed(e.px), norm_x_i);
        if (norm_y_i !== e.py) $error("norm_y exp %0d got %0d", $signed(e.py), norm_y_i);
        if (norm_z_i !== e.pz) $error("norm_z exp %0d got %0d", $signed(e.pz), norm_z_i);
        if (tex_u_i !== e.u) $error("tex_u exp %0d got %0d", e.u, tex_u_i);
        if (tex_v_i !== e.v) $error("tex_v exp %0d got %0d", e.v, tex_v_i);
        if (last_i !== e.last) $error("last exp %0d got %0d", e.last, last_i);
      end
    end
    pending_o = vertex_q.size();
  end

endmodule

[bench/tb_sphere_strip_vertex_gen.sv]
// Stimulus and verdict for the sphere strip vertex generator.
`timescale 1ns / 1ps
module tb_sphere_strip_vertex_gen;

  localparam int WATCHDOG = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0, in_stall_o;
  logic [8:0] lat_index_i = '0;
  logic [10:0] lon_index_i = '0;
  logic out_valid_o, out_stall_i = 1'b0;
  logic signed [15:0] pos_x_o, pos_y_o, pos_z_o, norm_x_o, norm_y_o, norm_z_o;
  logic [17:0] tex_u_o;
  logic [16:0] tex_v_o;
  logic last_o;
  logic [10:0] points_setting = 11'(ssvg_pkg::CFG_RST);
  int fail_count, pending, vertex_count, idle_cycles, cell_count;
  bit hold_off = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  sphere_strip_vertex_gen dut (.*);

  ssvg_checker u_checker (
    .clk_i, .rst_ni, .cfg_points_i(points_setting),
    .in_valid_i, .in_stall_i(in_stall_o), .lat_index_i, .lon_index_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .pos_x_i(pos_x_o), .pos_y_i(pos_y_o), .pos_z_i(pos_z_o),
    .norm_x_i(norm_x_o), .norm_y_i(norm_y_o), .norm_z_i(norm_z_o),
    .tex_u_i(tex_u_o), .tex_v_i(tex_v_o), .last_i(last_o),
    .fail_count_o(fail_count), .pending_o(pending), .vertex_count_o(vertex_count)
  );

  // Receiver stall pattern, with a long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_off) out_stall_i <= 1'b1;
    else case ($urandom_range(3))
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(3) == 0);
      2: out_stall_i <= ($urandom_range(1) == 0);
      default: out_stall_i <= out_stall_i ^ ($urandom_range(4) == 0);
    endcase
  end

  // Watchdog on cycles with no accepted request or vertex
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_points(input logic [10:0] value);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'(4 * ssvg_pkg::REG_POINTS);
    pwdata <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    points_setting = value;
  endtask

  // Send one cell request, holding it until accepted
  task automatic send_cell(input logic [8:0] lat, input logic [10:0] lon);
    in_valid_i <= 1'b1;
    lat_index_i <= lat;
    lon_index_i <= lon;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    cell_count++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  // Random cells in bursts; mostly in range, some saturating
  task automatic random_cells(input int count);
    int burst;
    logic [8:0] lat;
    logic [10:0] lon;
    int n;
    n = points_setting < 4 ? 4 : (points_setting > 1024 ? 1024 : points_setting);
    while (count > 0) begin
      burst = $urandom_range(12, 1);
      for (int k = 0; k < burst && count > 0; k++, count--) begin
        if ($urandom_range(4) == 0) begin
          lat = 9'($urandom); lon = 11'($urandom);
        end else begin
          lat = 9'($urandom_range(n / 2 - 1)); lon = 11'($urandom_range(n));
        end
        send_cell(lat, lon);
      end
      if ($urandom_range(2) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(6, 1)) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin
    logic [10:0] settings[6] = '{11'd4, 11'd1024, 11'd2047, 11'd7, 11'd0, 11'd64};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes and index saturation at reset setting and after writes of 1024 and 3
    send_cell(9'd0, 11'd0);
    send_cell(9'd31, 11'd64);
    send_cell(9'd511, 11'd2047);
    send_cell(9'd0, 11'd64);
    send_cell(9'd31, 11'd0);
    send_cell(9'h155, 11'h2aa);
    send_cell(9'h0aa, 11'h555);
    send_cell(9'd16, 11'd32);
    drain();
    write_points(11'd1024);
    send_cell(9'd511, 11'd1024);
    send_cell(9'd256, 11'd1023);
    send_cell(9'd0, 11'd2047);
    drain();
    write_points(11'd3);
    send_cell(9'd1, 11'd4);
    send_cell(9'd0, 11'd5);
    drain();

    // Long receiver hold-off while requests keep coming
    write_points(11'd64);
    hold_off = 1'b1;
    fork
      random_cells(30);
      begin
        repeat (200) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join
    drain();

    foreach (settings[s]) begin
      write_points(settings[s]);
      random_cells(90);
      drain();
    end

    $display("covered %0d cells, %0d vertices across points_per_turn settings",
             cell_count, vertex_count);
    $display("including min, max, odd, zero and oversize register values");
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
